FILE: src/ieia_pkg.sv
package ieia_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = 5;
    localparam int DATA_W = 32;
    localparam int POS_W  = 16;
    localparam int REQ_W  = 3;
    localparam int STAT_W = 3;

    localparam int IN_FIELDS_W  = REQ_W + POS_W + DATA_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STAT_W + DATA_W + CNT_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_ERASE  = 3'd2,
        REQ_READ   = 3'd3,
        REQ_FIRST  = 3'd4,
        REQ_LAST   = 3'd5
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 3'd0,
        ST_RANGE = 3'd1,
        ST_NEG   = 3'd2,
        ST_EMPTY = 3'd3,
        ST_FULL  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_READ,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } t_ram_req;

    typedef struct packed {
        logic              is_empty;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] read_value;
        logic [STAT_W-1:0] status;
    } t_result;

endpackage

FILE: src/ieia_ram.sv
module ieia_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/ieia_ctrl.sv
module ieia_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    output logic                                o_req_ready,
    input  logic [ieia_pkg::REQ_W-1:0]          i_req_type,
    input  logic [ieia_pkg::POS_W-1:0]          i_position,
    input  logic [ieia_pkg::DATA_W-1:0]         i_value,
    output ieia_pkg::t_ram_req                  o_ram,
    input  logic [ieia_pkg::DATA_W-1:0]         i_rdata,
    output logic                                o_res_valid,
    output ieia_pkg::t_result                   o_res,
    input  logic                                i_res_ready
);

    localparam int IDX_W  = ieia_pkg::IDX_W;
    localparam int CNT_W  = ieia_pkg::CNT_W;
    localparam int DATA_W = ieia_pkg::DATA_W;
    localparam int POS_W  = ieia_pkg::POS_W;

    ieia_pkg::t_state   r_state,  n_state;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic [IDX_W-1:0]   r_ptr,    n_ptr;
    logic [IDX_W-1:0]   r_idx,    n_idx;
    logic [DATA_W-1:0]  r_val,    n_val;
    logic               r_up,     n_up;
    ieia_pkg::t_status  r_status, n_status;
    logic [DATA_W-1:0]  r_rv,     n_rv;

    logic             neg;
    logic             above;
    logic             full;
    logic [IDX_W-1:0] pos_idx;

    assign neg     = i_position[POS_W-1];
    assign above   = !neg && (i_position >= POS_W'(r_count));
    assign full    = r_count >= CNT_W'(ieia_pkg::DEPTH);
    assign pos_idx = i_position[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ieia_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_ptr    <= n_ptr;
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_up     <= n_up;
        r_status <= n_status;
        r_rv     <= n_rv;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_idx       = r_idx;
        n_val       = r_val;
        n_up        = r_up;
        n_status    = r_status;
        n_rv        = r_rv;
        o_ram       = '0;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            ieia_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                o_ram.raddr = pos_idx;
                if (i_req_valid) begin
                    n_status = ieia_pkg::ST_OK;
                    n_rv     = '0;
                    n_state  = ieia_pkg::S_RESULT;
                    n_val    = i_value;
                    n_idx    = pos_idx;
                    unique case (i_req_type)
                        ieia_pkg::REQ_APPEND: begin
                            if (full) begin
                                n_status = ieia_pkg::ST_FULL;
                            end else begin
                                o_ram.we    = 1'b1;
                                o_ram.waddr = r_count[IDX_W-1:0];
                                o_ram.wdata = i_value;
                                n_count     = r_count + CNT_W'(1);
                            end
                        end
                        ieia_pkg::REQ_INSERT: begin
                            if (above) begin
                                n_status = ieia_pkg::ST_RANGE;
                            end else if (neg) begin
                                n_status = ieia_pkg::ST_NEG;
                            end else if (full) begin
                                n_status = ieia_pkg::ST_FULL;
                            end else begin
                                n_ptr   = r_count[IDX_W-1:0];
                                n_up    = 1'b1;
                                n_state = (r_count[IDX_W-1:0] == pos_idx) ?
                                          ieia_pkg::S_PUT : ieia_pkg::S_SHIFT_RD;
                            end
                        end
                        ieia_pkg::REQ_ERASE: begin
                            if (above) begin
                                n_status = ieia_pkg::ST_RANGE;
                            end else if (neg) begin
                                n_status = ieia_pkg::ST_NEG;
                            end else if (CNT_W'(pos_idx) + CNT_W'(1) >= r_count) begin
                                // erasing the last element, nothing moves
                                n_count = r_count - CNT_W'(1);
                            end else begin
                                n_ptr   = pos_idx;
                                n_up    = 1'b0;
                                n_state = ieia_pkg::S_SHIFT_RD;
                            end
                        end
                        ieia_pkg::REQ_READ: begin
                            if (above) begin
                                n_status = ieia_pkg::ST_RANGE;
                            end else if (neg) begin
                                n_status = ieia_pkg::ST_NEG;
                            end else begin
                                n_state = ieia_pkg::S_READ;
                            end
                        end
                        ieia_pkg::REQ_FIRST: begin
                            o_ram.raddr = '0;
                            if (r_count == '0) begin
                                n_status = ieia_pkg::ST_EMPTY;
                            end else begin
                                n_state = ieia_pkg::S_READ;
                            end
                        end
                        ieia_pkg::REQ_LAST: begin
                            o_ram.raddr = r_count[IDX_W-1:0] - IDX_W'(1);
                            if (r_count == '0) begin
                                n_status = ieia_pkg::ST_EMPTY;
                            end else begin
                                n_state = ieia_pkg::S_READ;
                            end
                        end
                        default: begin
                            n_status = ieia_pkg::ST_RANGE;
                        end
                    endcase
                end
            end
            ieia_pkg::S_SHIFT_RD: begin
                // fetch the neighbor that moves into r_ptr
                o_ram.raddr = r_up ? (r_ptr - IDX_W'(1)) : (r_ptr + IDX_W'(1));
                n_state     = ieia_pkg::S_SHIFT_WR;
            end
            ieia_pkg::S_SHIFT_WR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_ptr;
                o_ram.wdata = i_rdata;
                if (r_up) begin
                    n_ptr   = r_ptr - IDX_W'(1);
                    n_state = ((r_ptr - IDX_W'(1)) == r_idx) ?
                              ieia_pkg::S_PUT : ieia_pkg::S_SHIFT_RD;
                end else begin
                    n_ptr = r_ptr + IDX_W'(1);
                    if (CNT_W'(r_ptr) + CNT_W'(2) >= r_count) begin
                        n_count = r_count - CNT_W'(1);
                        n_state = ieia_pkg::S_RESULT;
                    end else begin
                        n_state = ieia_pkg::S_SHIFT_RD;
                    end
                end
            end
            ieia_pkg::S_PUT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx;
                o_ram.wdata = r_val;
                n_count     = r_count + CNT_W'(1);
                n_state     = ieia_pkg::S_RESULT;
            end
            ieia_pkg::S_READ: begin
                n_rv    = i_rdata;
                n_state = ieia_pkg::S_RESULT;
            end
            ieia_pkg::S_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ieia_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ieia_pkg::S_IDLE;
            end
        endcase
    end

    assign o_res.status     = r_status;
    assign o_res.read_value = r_rv;
    assign o_res.count      = r_count;
    assign o_res.is_empty   = (r_count == '0);

endmodule

FILE: src/indexed_insert_erase_array_core.sv
// ordered array of up to 16 signed 32-bit elements behind one simple dual-port
// element memory (one write and one registered read per cycle) that a small
// sequencer walks for every request. each transfer in gives exactly one
// transfer out carrying status, read value, element count and empty flag;
// failed requests leave the array untouched. append and every failed request
// go straight to the result state; read at index / first / last passes
// through a read state that captures the registered memory data; insert
// moves every element from the end down to the index up by one and then
// puts the value; erase moves every element above the index down by one.
// each shifted element takes one memory read and one memory write, and the
// shifting sets the cost of those requests. the input side is not ready while
// a request is being worked on; a finished result sits in an output register,
// so the next request can be taken while the downstream side still stalls
module indexed_insert_erase_array_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [2:0] req_type, [18:3] position, [50:19] value, rest zero
    input  logic [ieia_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // result stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [2:0] status, [34:3] read_value, [39:35] count, [40] is_empty, rest zero
    output logic [ieia_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);

    localparam int REQ_W  = ieia_pkg::REQ_W;
    localparam int POS_W  = ieia_pkg::POS_W;
    localparam int DATA_W = ieia_pkg::DATA_W;

    // unpacked request fields
    logic [REQ_W-1:0]  req_type;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;

    assign req_type = i_s_axis_tdata[REQ_W-1:0];
    assign position = i_s_axis_tdata[REQ_W+POS_W-1:REQ_W];
    assign value    = i_s_axis_tdata[REQ_W+POS_W+DATA_W-1:REQ_W+POS_W];

    ieia_pkg::t_ram_req ram_req;
    logic [DATA_W-1:0]  ram_rdata;
    logic               res_valid;
    logic               res_ready;
    ieia_pkg::t_result  res;

    // output register
    logic              r_out_valid;
    ieia_pkg::t_result r_out;

    // element storage
    ieia_ram #(
        .DATA_W (DATA_W),
        .DEPTH  (ieia_pkg::DEPTH),
        .ADDR_W (ieia_pkg::IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // request decode, range checks and shift sequencer
    ieia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_req_type  (req_type),
        .i_position  (position),
        .i_value     (value),
        .o_ram       (ram_req),
        .i_rdata     (ram_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // result moves into the output register once it is empty or draining
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(ieia_pkg::OUT_TDATA_W - ieia_pkg::OUT_FIELDS_W){1'b0}}, r_out};

    // no request is taken while a result is still inside the sequencer
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !res_valid)
        else $error("sequencer ready while holding a result");

    // an accepted request always closes the input side for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input still ready after accepting a request");

    // count never exceeds capacity and the empty flag follows it
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_out.count <= ieia_pkg::CNT_W'(ieia_pkg::DEPTH))
                            && (r_out.is_empty == (r_out.count == '0)))
        else $error("result count or empty flag inconsistent");

    // a stalled result holds steady in the output register
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(r_out) && o_m_axis_tvalid)
        else $error("output register changed under stall");

endmodule

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REQ_W        = ieia_pkg::REQ_W;
    localparam int POS_W        = ieia_pkg::POS_W;
    localparam int DATA_W       = ieia_pkg::DATA_W;
    localparam int CNT_W        = ieia_pkg::CNT_W;
    localparam int DEPTH        = ieia_pkg::DEPTH;
    localparam int IN_FIELDS_W  = ieia_pkg::IN_FIELDS_W;
    localparam int IN_TDATA_W   = ieia_pkg::IN_TDATA_W;
    localparam int OUT_FIELDS_W = ieia_pkg::OUT_FIELDS_W;
    localparam int OUT_TDATA_W  = ieia_pkg::OUT_TDATA_W;

    // request codes that the block does not define
    localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

    // outlasts the longest insert, so this covers any request in flight
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
    localparam int MAX_REPORTS   = 10;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // [2:0] req_type, [18:3] position, [50:19] value, rest zero
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [2:0] status, [34:3] read_value, [39:35] count, [40] is_empty, rest zero
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    indexed_insert_erase_array_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // shadow copy of the array, updated in transfer order
    logic [DATA_W-1:0] shadow_mem [DEPTH];
    int                shadow_fill = 0;
    // responses still owed by the block, oldest first
    ieia_pkg::t_result owed_responses [$];
    int                fault_count = 0;
    // percent of cycles in which the request side holds back / the response side stalls
    int                src_gap_pct = 0;
    int                sink_stall_pct = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // applies one accepted request to the shadow array and returns its response
    function automatic ieia_pkg::t_result apply_request(input logic [REQ_W-1:0] kind,
                                                        input logic [POS_W-1:0] pos,
                                                        input logic [DATA_W-1:0] val);
        ieia_pkg::t_result res;
        logic              neg;
        logic              above;
        int                idx;
        neg            = pos[POS_W-1];
        idx            = int'(pos);
        // a non-negative index past the last element is out of range, checked first
        above          = !neg && (idx >= shadow_fill);
        res.status     = ieia_pkg::ST_OK;
        res.read_value = '0;
        case (kind)
            ieia_pkg::REQ_APPEND: begin
                if (shadow_fill >= DEPTH) begin
                    res.status = ieia_pkg::ST_FULL;
                end else begin
                    shadow_mem[shadow_fill] = val;
                    shadow_fill++;
                end
            end
            ieia_pkg::REQ_INSERT: begin
                if (above) begin
                    res.status = ieia_pkg::ST_RANGE;
                end else if (neg) begin
                    res.status = ieia_pkg::ST_NEG;
                end else if (shadow_fill >= DEPTH) begin
                    res.status = ieia_pkg::ST_FULL;
                end else begin
                    for (int i = shadow_fill; i > idx; i--) shadow_mem[i] = shadow_mem[i-1];
                    shadow_mem[idx] = val;
                    shadow_fill++;
                end
            end
            ieia_pkg::REQ_ERASE: begin
                if (above) begin
                    res.status = ieia_pkg::ST_RANGE;
                end else if (neg) begin
                    res.status = ieia_pkg::ST_NEG;
                end else begin
                    for (int i = idx; i + 1 < shadow_fill; i++) shadow_mem[i] = shadow_mem[i+1];
                    shadow_fill--;
                end
            end
            ieia_pkg::REQ_READ: begin
                if (above) begin
                    res.status = ieia_pkg::ST_RANGE;
                end else if (neg) begin
                    res.status = ieia_pkg::ST_NEG;
                end else begin
                    res.read_value = shadow_mem[idx];
                end
            end
            ieia_pkg::REQ_FIRST: begin
                if (shadow_fill == 0) res.status = ieia_pkg::ST_EMPTY;
                else res.read_value = shadow_mem[0];
            end
            ieia_pkg::REQ_LAST: begin
                if (shadow_fill == 0) res.status = ieia_pkg::ST_EMPTY;
                else res.read_value = shadow_mem[shadow_fill-1];
            end
            default: begin
                res.status = ieia_pkg::ST_RANGE;
            end
        endcase
        res.count    = CNT_W'(shadow_fill);
        res.is_empty = (shadow_fill == 0);
        return res;
    endfunction

    // response side: random stalls, driven on the falling edge
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // response checker, sampled on the rising edge
    always @(posedge i_clk) begin
        ieia_pkg::t_result got;
        ieia_pkg::t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = ieia_pkg::t_result'(o_m_axis_tdata[OUT_FIELDS_W-1:0]);
            if (owed_responses.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("tb: unexpected response status %0d value %h count %0d empty %0b",
                             got.status, got.read_value, got.count, got.is_empty);
            end else begin
                want = owed_responses.pop_front();
                if (got.status !== want.status || got.read_value !== want.read_value ||
                    got.count !== want.count || got.is_empty !== want.is_empty) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("tb: mismatch st/val/cnt/emp exp %0d %h %0d %0b got %0d %h %0d %0b",
                                 want.status, want.read_value, want.count, want.is_empty,
                                 got.status, got.read_value, got.count, got.is_empty);
                end
            end
        end
    end

    // one request transfer; entered and left on a falling edge with tvalid still high
    task automatic issue_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                                 input logic [DATA_W-1:0] val);
        ieia_pkg::t_result next_resp;
        if ($urandom_range(99) < src_gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < src_gap_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_TDATA_W-IN_FIELDS_W){1'b0}}, val, pos, kind};
        do @(posedge i_clk); while (!o_s_axis_tready);
        next_resp      = apply_request(kind, pos, val);
        owed_responses = {owed_responses, next_resp};
        @(negedge i_clk);
    endtask

    // stop sending until every owed response has come back
    task automatic hold_until_drained();
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (owed_responses.size() != 0) @(negedge i_clk);
    endtask

    // every failing request on an empty array, plus an undefined code
    task automatic test_empty_array();
        issue_request(ieia_pkg::REQ_FIRST,  16'h0000, 32'h0);
        issue_request(ieia_pkg::REQ_LAST,   16'hFFFF, 32'h0);
        issue_request(ieia_pkg::REQ_READ,   16'h0000, 32'h0);
        issue_request(ieia_pkg::REQ_ERASE,  16'hFFFF, 32'h0);
        // insert into an empty array: non-negative index is out of range
        issue_request(ieia_pkg::REQ_INSERT, 16'h0000, 32'hDEAD_BEEF);
        issue_request(ieia_pkg::REQ_INSERT, 16'h8000, 32'hDEAD_BEEF);
        issue_request(REQ_SPARE_A, 16'h7FFF, 32'hFFFF_FFFF);
    endtask

    // fill with extreme values, then hit the full checks
    task automatic test_fill_to_full();
        issue_request(ieia_pkg::REQ_APPEND, 16'h0000, 32'h8000_0000);
        issue_request(ieia_pkg::REQ_APPEND, 16'hFFFF, 32'h7FFF_FFFF);
        issue_request(ieia_pkg::REQ_APPEND, 16'h0000, 32'hFFFF_FFFF);
        issue_request(ieia_pkg::REQ_INSERT, 16'h0000, 32'h0000_0000);
        // last legal insert index is count-1
        issue_request(ieia_pkg::REQ_INSERT, POS_W'(shadow_fill - 1), 32'h5A5A_A5A5);
        while (shadow_fill < DEPTH) issue_request(ieia_pkg::REQ_APPEND, 16'h0000, $urandom);
        issue_request(ieia_pkg::REQ_APPEND, 16'h0000, 32'h1111_1111);
        issue_request(ieia_pkg::REQ_INSERT, 16'h0000, 32'h2222_2222);
        // index equal to count beats the full check
        issue_request(ieia_pkg::REQ_INSERT, POS_W'(DEPTH), 32'h3333_3333);
        hold_until_drained();
    endtask

    // reads at the ends and out of range, erase at both ends
    task automatic test_reads_and_erases();
        issue_request(ieia_pkg::REQ_FIRST, 16'h0000, 32'h0);
        issue_request(ieia_pkg::REQ_LAST,  16'h0000, 32'h0);
        issue_request(ieia_pkg::REQ_READ,  POS_W'(DEPTH - 1), 32'h0);
        issue_request(ieia_pkg::REQ_READ,  16'h7FFF, 32'h0);
        issue_request(ieia_pkg::REQ_READ,  16'h8000, 32'h0);
        issue_request(ieia_pkg::REQ_ERASE, POS_W'(DEPTH), 32'h0);
        issue_request(ieia_pkg::REQ_ERASE, POS_W'(DEPTH - 1), 32'h0);
        issue_request(ieia_pkg::REQ_ERASE, 16'h0000, 32'h0);
        issue_request(REQ_SPARE_B, 16'h0000, 32'h0);
    endtask

    // random requests biased toward legal indices, with a little noise
    task automatic test_random_traffic(input int n_items, input int gap_pct, input int stall_pct);
        int                roll;
        int                grow_w;
        logic [REQ_W-1:0]  kind;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        src_gap_pct    = gap_pct;
        sink_stall_pct = stall_pct;
        repeat (n_items) begin
            // near full, lean toward erase so the array keeps cycling
            grow_w = (shadow_fill > DEPTH - 4) ? 25 : 50;
            roll   = $urandom_range(99);
            if (roll < 6) begin
                kind = REQ_W'($urandom_range(7));
            end else begin
                roll = $urandom_range(99);
                if (roll < grow_w)
                    kind = $urandom_range(1) ? ieia_pkg::REQ_INSERT : ieia_pkg::REQ_APPEND;
                else if (roll < 75) kind = ieia_pkg::REQ_ERASE;
                else if (roll < 87) kind = ieia_pkg::REQ_READ;
                else kind = $urandom_range(1) ? ieia_pkg::REQ_FIRST : ieia_pkg::REQ_LAST;
            end
            roll = $urandom_range(99);
            if (roll < 80) pos = POS_W'($urandom_range(shadow_fill > 0 ? shadow_fill - 1 : 0));
            else if (roll < 88) pos = POS_W'(shadow_fill);
            else if (roll < 94) pos = {1'b1, 15'($urandom)};
            else pos = POS_W'($urandom);
            case ($urandom_range(11))
                0: val = 32'h8000_0000;
                1: val = 32'h7FFF_FFFF;
                2: val = 32'hFFFF_FFFF;
                3: val = 32'h0000_0000;
                default: val = $urandom;
            endcase
            issue_request(kind, pos, val);
        end
        hold_until_drained();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_gap_pct    = 18;
        sink_stall_pct = 45;
        test_empty_array();
        test_fill_to_full();
        test_reads_and_erases();

        test_random_traffic(135, 18, 45);
        test_random_traffic(135, 45, 18);
        test_random_traffic(130, 0, 0);

        i_s_axis_tvalid <= 1'b0;
        while (owed_responses.size() != 0) @(posedge i_clk);
        // catch any stray response after the last expected one
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && owed_responses.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: indexed_insert_erase_array_core.f
src/ieia_pkg.sv
src/ieia_ram.sv
src/ieia_ctrl.sv
src/indexed_insert_erase_array_core.sv
tb/tb.sv
